/* rtl/b64d_pkg.sv */
// ----------------------------------------------------------------------------
// b64d_pkg: shared types and constants of the base64 stream decoder
// Holds the classified-character entry, the result record and the codes
// used by the front end and the decode back end.
// ----------------------------------------------------------------------------
package b64d_pkg;

  // Characters with a meaning of their own
  localparam logic [7:0] CHAR_NL     = 8'h0a;
  localparam logic [7:0] CHAR_EQ     = 8'h3d;
  localparam logic [7:0] CHAR_DOT    = 8'h2e;
  localparam logic [7:0] CHAR_PLUS   = 8'h2b;
  localparam logic [7:0] CHAR_MINUS  = 8'h2d;
  localparam logic [7:0] CHAR_SLASH  = 8'h2f;
  localparam logic [7:0] CHAR_UNDER  = 8'h5f;
  localparam logic [7:0] CHAR_UP_A   = 8'h41;
  localparam logic [7:0] CHAR_LO_A   = 8'h61;
  localparam logic [7:0] CHAR_ZERO   = 8'h30;

  // Sextet codes of the two symbol characters and of 'a' and '0'
  localparam logic [5:0] SEXTET_62   = 6'd62;
  localparam logic [5:0] SEXTET_63   = 6'd63;
  localparam logic [5:0] SEXTET_LO_A = 6'd26;
  localparam logic [5:0] SEXTET_ZERO = 6'd52;

  // Bit masks applied to sextets while forming bytes
  localparam logic [5:0] MASK_HI2    = 6'h30;
  localparam logic [5:0] MASK_LO4    = 6'h0f;
  localparam logic [5:0] MASK_MID4   = 6'h3c;
  localparam logic [5:0] MASK_LO2    = 6'h03;

  // Position of a character inside its four-character chunk
  localparam logic [1:0] CHUNK_P0    = 2'd0;
  localparam logic [1:0] CHUNK_P1    = 2'd1;
  localparam logic [1:0] CHUNK_P2    = 2'd2;
  localparam logic [1:0] CHUNK_P3    = 2'd3;

  // One classified character as it travels from front end to back end
  typedef struct packed {
    logic       drop;     // stripped newline, takes no chunk position
    logic       pad;      // '=' or '.'
    logic       ok;       // member of either alphabet
    logic [5:0] sextet;   // decoded value, zero when not ok
    logic       last;     // closes the string
  } b64d_cls_t;

  // One result record
  typedef struct packed {
    logic [7:0] data;
    logic       byte_valid;
    logic       eos;
    logic       err;
  } b64d_res_t;

endpackage

/* rtl/b64d_front.sv */
// ----------------------------------------------------------------------------
// b64d_front: input request acceptance and character classification
// Holds the newline-strip register, maps each character to its sextet and
// flags, and pushes the classified character into the queue.
// ----------------------------------------------------------------------------
module b64d_front
  import b64d_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,
  input  logic       in_tlast,
  input  logic       q_ready,
  output logic       q_push,
  output b64d_cls_t  q_entry
);

  logic       strip_r;
  logic [7:0] diff_up;
  logic [7:0] diff_lo;
  logic [7:0] diff_dg;

  // Hold the strip register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strip_r <= 1'b0;
    end else if (cfg_wr_en) begin
      strip_r <= cfg_wr_data;
    end
  end

  assign in_tready = q_ready;
  assign q_push    = in_tvalid & q_ready;

  assign diff_up = in_tdata - CHAR_UP_A;
  assign diff_lo = in_tdata - CHAR_LO_A;
  assign diff_dg = in_tdata - CHAR_ZERO;

  // Classify the character
  always_comb begin
    q_entry.drop   = strip_r & (in_tdata == CHAR_NL);
    q_entry.pad    = (in_tdata == CHAR_EQ) | (in_tdata == CHAR_DOT);
    q_entry.last   = in_tlast;
    q_entry.ok     = 1'b1;
    q_entry.sextet = '0;
    if (in_tdata inside {[8'h41:8'h5a]}) begin
      q_entry.sextet = diff_up[5:0];
    end else if (in_tdata inside {[8'h61:8'h7a]}) begin
      q_entry.sextet = diff_lo[5:0] + SEXTET_LO_A;
    end else if (in_tdata inside {[8'h30:8'h39]}) begin
      q_entry.sextet = diff_dg[5:0] + SEXTET_ZERO;
    end else if (in_tdata inside {CHAR_PLUS, CHAR_MINUS}) begin
      q_entry.sextet = SEXTET_62;
    end else if (in_tdata inside {CHAR_SLASH, CHAR_UNDER}) begin
      q_entry.sextet = SEXTET_63;
    end else begin
      q_entry.ok = 1'b0;
    end
  end

endmodule

/* rtl/b64d_queue.sv */
// ----------------------------------------------------------------------------
// b64d_queue: short queue of classified characters
// Decouples the front end from the decode back end; push and pop may
// happen in the same cycle.
// ----------------------------------------------------------------------------
module b64d_queue
  import b64d_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  b64d_cls_t push_entry,
  output logic      push_ready,
  input  logic      pop,
  output logic      pop_valid,
  output b64d_cls_t pop_entry
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  b64d_cls_t     slot_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign push_ready = (count_r != CNT_FULL);
  assign pop_valid  = (count_r != '0);
  assign pop_entry  = slot_r[rd_ptr_r];
  assign do_push    = push & push_ready;
  assign do_pop     = pop & pop_valid;

  // Advance pointers and count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the pushed entry
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_FULL)
    else $error("queue count above depth");

  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> (count_r == $past(count_r) + 1'b1))
    else $error("queue count missed a push");

  a_count_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (do_pop && !do_push) |=> (count_r == $past(count_r) - 1'b1))
    else $error("queue count missed a pop");

endmodule

/* rtl/b64d_back.sv */
// ----------------------------------------------------------------------------
// b64d_back: chunk decode and result register
// Tracks chunk position, previous sextet, padding and error state, forms
// bytes and holds each result in an output register until taken.
// ----------------------------------------------------------------------------
module b64d_back
  import b64d_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_valid,
  input  b64d_cls_t  q_entry,
  output logic       q_pop,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,   // out_byte
  output logic [1:0] out_tuser,   // [0] byte_valid, [1] decode_error
  output logic       out_tlast    // end_of_string
);

  logic [1:0] pos_r, pos_nxt;
  logic [5:0] prev_r, prev_nxt;
  logic       skip_r, skip_nxt;
  logic       err_r, err_nxt;
  logic       have;
  logic [7:0] byte_val;
  logic       emit;
  b64d_res_t  res;
  b64d_res_t  res_r;
  logic       res_valid_r, res_valid_nxt;

  assign q_pop = q_valid & (~res_valid_r | out_tready);

  // Decode one classified character against the chunk state
  always_comb begin
    pos_nxt  = pos_r;
    prev_nxt = prev_r;
    skip_nxt = skip_r;
    err_nxt  = err_r;
    have     = 1'b0;
    byte_val = '0;
    if (!q_entry.drop) begin
      case (pos_r)
        CHUNK_P0: begin
          if (!q_entry.ok) err_nxt = 1'b1;
          prev_nxt = q_entry.sextet;
        end
        CHUNK_P1: begin
          if (!q_entry.ok) begin
            err_nxt = 1'b1;
          end else begin
            byte_val = {prev_r, 2'((q_entry.sextet & MASK_HI2) >> 4)};
            have     = 1'b1;
          end
          prev_nxt = q_entry.sextet;
        end
        CHUNK_P2: begin
          if (q_entry.pad) begin
            skip_nxt = 1'b1;
          end else if (!q_entry.ok) begin
            err_nxt = 1'b1;
          end else begin
            byte_val = {4'(prev_r & MASK_LO4), 4'((q_entry.sextet & MASK_MID4) >> 2)};
            have     = 1'b1;
          end
          prev_nxt = q_entry.sextet;
        end
        default: begin
          if (skip_r || q_entry.pad) begin
            // ignore the character or drop the third byte
          end else if (!q_entry.ok) begin
            err_nxt = 1'b1;
          end else begin
            byte_val = {2'(prev_r & MASK_LO2), q_entry.sextet};
            have     = 1'b1;
          end
          skip_nxt = 1'b0;
          prev_nxt = '0;
        end
      endcase
      pos_nxt = pos_r + 1'b1;
      if (err_nxt) begin
        have     = 1'b0;
        byte_val = '0;
      end
    end
    emit           = have | q_entry.last;
    res.data       = byte_val;
    res.byte_valid = have;
    res.eos        = q_entry.last;
    res.err        = q_entry.last & (err_nxt | (pos_nxt == CHUNK_P1));
    if (q_entry.last) begin
      pos_nxt  = CHUNK_P0;
      prev_nxt = '0;
      skip_nxt = 1'b0;
      err_nxt  = 1'b0;
    end
  end

  // Advance chunk state on each pop
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= CHUNK_P0;
      prev_r <= '0;
      skip_r <= 1'b0;
      err_r  <= 1'b0;
    end else if (q_pop) begin
      pos_r  <= pos_nxt;
      prev_r <= prev_nxt;
      skip_r <= skip_nxt;
      err_r  <= err_nxt;
    end
  end

  // Hold the result until the request is taken
  always_comb begin
    res_valid_nxt = res_valid_r & ~out_tready;
    if (q_pop && emit) res_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else begin
      res_valid_r <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && emit) begin
      res_r <= res;
    end
  end

  assign out_tvalid   = res_valid_r;
  assign out_tdata    = res_r.data;
  assign out_tuser[0] = res_r.byte_valid;
  assign out_tuser[1] = res_r.err;
  assign out_tlast    = res_r.eos;

  a_err_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid_r && res_r.err) |-> res_r.eos)
    else $error("error flag outside the closing result");

  a_no_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid_r && !res_r.byte_valid) |-> (res_r.data == '0))
    else $error("data nonzero without a byte");

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && q_entry.last) |=> (pos_r == CHUNK_P0 && !err_r && !skip_r))
    else $error("string state not cleared at end");

  a_no_byte_after_err: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && err_r && !q_entry.drop) |-> !have)
    else $error("byte formed after an error");

endmodule

/* rtl/base64_stream_decoder_core.sv */
// ----------------------------------------------------------------------------
// base64_stream_decoder_core: streaming base64 decoder, both alphabets
// Front end classifies characters, a short queue decouples it from the
// decode back end, which forms bytes and reports errors at string end.
// ----------------------------------------------------------------------------
//  channel  | direction | payload
//  in_      | slave     | tdata[7:0] char_in, tlast last_char
//  out_     | master    | tdata[7:0] out_byte, tuser[0] byte_valid,
//           |           | tuser[1] decode_error, tlast end_of_string
//  cfg_     | write     | wr_data strip_newlines
//
//  One character per cycle sustained while the queue has room; a result is
//  presented from the result register, which is loaded from the queue slot
//  written when its character is accepted.
//  The back end retires one queued character per cycle unless a result stalls.
//  Synchronous reset clears all string state and the strip register.
//  A stalled output holds its result; the queue then fills and in_tready
//  drops once the queue holds QUEUE_DEPTH characters.
// ----------------------------------------------------------------------------
module base64_stream_decoder_core
  import b64d_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data,  // strip_newlines
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,     // [7:0] char_in
  input  logic       in_tlast,     // last_char
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,    // [7:0] out_byte
  output logic [1:0] out_tuser,    // [0] byte_valid, [1] decode_error
  output logic       out_tlast     // end_of_string
);

  logic      q_ready;
  logic      q_push;
  b64d_cls_t q_in;
  logic      q_pop;
  logic      q_valid;
  b64d_cls_t q_out;

  b64d_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .q_ready     (q_ready),
    .q_push      (q_push),
    .q_entry     (q_in)
  );

  b64d_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_in),
    .push_ready (q_ready),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_entry  (q_out)
  );

  b64d_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_entry    (q_out),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

/* verif/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: testbench of the base64 stream decoder core
// Streams encoded strings into the decoder and checks every decoded byte and
// every end-of-string flag against a cycle-free decoder model kept inside the
// bench. Directed strings cover both alphabets, padding, errors and newline
// stripping; random phases mix well-formed strings, broken strings and noise
// across both strip settings, most under bursty input and a stalling output.
// ----------------------------------------------------------------------------
module tb_top;
  import b64d_pkg::*;

  localparam int CLK_PERIOD   = 8;
  localparam int PIPE_SETTLE  = 6;       // idle clocks after the last expected result
  localparam int CYCLE_LIMIT  = 300000;

  logic       clk;
  logic       rst_n;
  logic       cfg_wr_en;
  logic       cfg_wr_data;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;     // [7:0] char_in
  logic       in_tlast;     // last_char
  logic       out_tvalid;
  logic       out_tready;
  logic [7:0] out_tdata;    // [7:0] out_byte
  logic [1:0] out_tuser;    // [0] byte_valid, [1] decode_error
  logic       out_tlast;    // end_of_string

  // Decoder model state and its copy of the strip register
  logic       strip_q;
  logic [1:0] pos_q;
  logic [5:0] prev_q;
  logic       skip_q;
  logic       err_q;

  // Results still owed by the decoder, oldest first
  b64d_res_t  decoded_q[$];
  b64d_res_t  want;

  int cycle_cnt;
  int fail_cnt;
  int chars_sent;
  int strings_sent;
  int results_seen;
  int bytes_seen;
  int bad_strings;

  // Sender and receiver idle controls
  int tx_mode;
  int tx_burst_left;
  int rx_mode;
  int rx_hold;

  base64_stream_decoder_core dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Abort on a hang
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding",
               cycle_cnt, decoded_q.size());
      $display("Some tests failed");
      $finish;
    end
  end

  // Stall the output: short random holds, longer ones in heavy mode
  always @(posedge clk) begin
    if (rx_hold != 0) begin
      rx_hold--;
      out_tready <= 1'b0;
    end else if (rx_mode != 0 &&
                 $urandom_range(0, (rx_mode == 1) ? 7 : 2) == 0) begin
      rx_hold = $urandom_range(0, (rx_mode == 1) ? 3 : 9);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (decoded_q.size() == 0) begin
        $error("unexpected result: out_byte %h tuser %b tlast %b",
               out_tdata, out_tuser, out_tlast);
        fail_cnt++;
      end else begin
        want = decoded_q.pop_front();
        if (out_tdata !== want.data) begin
          $error("out_byte: expected %h, got %h", want.data, out_tdata);
          fail_cnt++;
        end
        if (out_tuser[0] !== want.byte_valid) begin
          $error("byte_valid: expected %b, got %b", want.byte_valid, out_tuser[0]);
          fail_cnt++;
        end
        if (out_tuser[1] !== want.err) begin
          $error("decode_error: expected %b, got %b", want.err, out_tuser[1]);
          fail_cnt++;
        end
        if (out_tlast !== want.eos) begin
          $error("end_of_string: expected %b, got %b", want.eos, out_tlast);
          fail_cnt++;
        end
        if (want.byte_valid) bytes_seen++;
        if (want.eos && want.err) bad_strings++;
      end
    end
  end

  // Advance the decoder model by one accepted request
  function automatic void decode_char(input logic [7:0] c, input logic l);
    logic [5:0] sx;
    logic [7:0] b;
    logic       ok;
    logic       pad;
    logic       have;
    b64d_res_t  r;
    sx   = '0;
    b    = '0;
    ok   = 1'b1;
    have = 1'b0;
    if (!(strip_q && c == CHAR_NL)) begin
      pad = (c == CHAR_EQ) || (c == CHAR_DOT);
      if (c >= CHAR_UP_A && c <= CHAR_UP_A + 8'd25)
        sx = 6'(c - CHAR_UP_A);
      else if (c >= CHAR_LO_A && c <= CHAR_LO_A + 8'd25)
        sx = 6'(c - CHAR_LO_A + SEXTET_LO_A);
      else if (c >= CHAR_ZERO && c <= CHAR_ZERO + 8'd9)
        sx = 6'(c - CHAR_ZERO + SEXTET_ZERO);
      else if (c == CHAR_PLUS || c == CHAR_MINUS)
        sx = SEXTET_62;
      else if (c == CHAR_SLASH || c == CHAR_UNDER)
        sx = SEXTET_63;
      else
        ok = 1'b0;
      case (pos_q)
        CHUNK_P0: begin
          if (!ok) err_q = 1'b1;
          prev_q = sx;
        end
        CHUNK_P1: begin
          if (!ok) begin
            err_q = 1'b1;
          end else begin
            b    = {prev_q, sx[5:4]};
            have = 1'b1;
          end
          prev_q = sx;
        end
        CHUNK_P2: begin
          if (pad) begin
            skip_q = 1'b1;
          end else if (!ok) begin
            err_q = 1'b1;
          end else begin
            b    = {prev_q[3:0], sx[5:2]};
            have = 1'b1;
          end
          prev_q = sx;
        end
        default: begin
          // after padding at position 2 the fourth character means nothing
          if (!skip_q && !pad) begin
            if (!ok) begin
              err_q = 1'b1;
            end else begin
              b    = {prev_q[1:0], sx};
              have = 1'b1;
            end
          end
          skip_q = 1'b0;
          prev_q = '0;
        end
      endcase
      pos_q = pos_q + 2'd1;
      if (err_q) begin
        have = 1'b0;
        b    = '0;
      end
    end
    if (have || l) begin
      r.data       = b;
      r.byte_valid = have;
      r.eos        = l;
      r.err        = l && (err_q || pos_q == CHUNK_P1);
      decoded_q.insert(decoded_q.size(), r);
    end
    if (l) begin
      pos_q  = '0;
      prev_q = '0;
      skip_q = 1'b0;
      err_q  = 1'b0;
    end
  endfunction

  // Send one request; when bursty, open a random gap once the burst is used up
  task automatic send_char(input logic [7:0] c, input logic l);
    if (tx_mode != 0 && tx_burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      tx_burst_left = $urandom_range(1, 12);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tlast  <= l;
    do @(posedge clk); while (!in_tready);
    decode_char(c, l);
    chars_sent++;
    if (l) strings_sent++;
    if (tx_burst_left > 0) tx_burst_left--;
  endtask

  task automatic send_text(input string s, input bit mark_last);
    for (int i = 0; i < s.len(); i++)
      send_char(s[i], mark_last && (i == s.len() - 1));
  endtask

  // Hold off the sender until every result is in and the pipe is empty
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (PIPE_SETTLE) @(posedge clk);
  endtask

  task automatic write_strip(input logic v);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    strip_q = v;
  endtask

  function automatic logic [7:0] rand_alpha();
    int k;
    k = $urandom_range(0, 65);
    if (k < 26) return 8'(CHAR_UP_A + k);
    if (k < 52) return 8'(CHAR_LO_A + k - 26);
    if (k < 62) return 8'(CHAR_ZERO + k - 52);
    case (k)
      62:      return CHAR_PLUS;
      63:      return CHAR_SLASH;
      64:      return CHAR_MINUS;
      default: return CHAR_UNDER;
    endcase
  endfunction

  function automatic logic [7:0] rand_pad();
    return ($urandom_range(0, 1) != 0) ? CHAR_EQ : CHAR_DOT;
  endfunction

  // Build one encoded string, optionally damaged, and send it
  task automatic send_random_string(input bit broken);
    logic [7:0] chars[$];
    int nchunks;
    nchunks = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20) : $urandom_range(0, 4);
    repeat (nchunks * 4) chars.insert(chars.size(), rand_alpha());
    case ($urandom_range(0, 4))
      1: begin
        repeat (2) chars.insert(chars.size(), rand_alpha());
        chars.insert(chars.size(), rand_pad());
        chars.insert(chars.size(), ($urandom_range(0, 1) != 0) ? rand_pad()
                                                               : 8'($urandom_range(0, 255)));
      end
      2: begin
        repeat (3) chars.insert(chars.size(), rand_alpha());
        chars.insert(chars.size(), rand_pad());
      end
      3: repeat (2) chars.insert(chars.size(), rand_alpha());
      4: repeat (3) chars.insert(chars.size(), rand_alpha());
      default: ;
    endcase
    if (broken) begin
      case ($urandom_range(0, 3))
        0: begin
          // end the string one character into a chunk
          chars.delete();
          repeat ($urandom_range(0, 3) * 4 + 1) chars.insert(chars.size(), rand_alpha());
        end
        1: chars.insert($urandom_range(0, chars.size()), 8'($urandom_range(0, 255)));
        2: chars.insert($urandom_range(0, chars.size()), rand_pad());
        default: chars.insert($urandom_range(0, chars.size()), CHAR_NL);
      endcase
    end
    if (strip_q)
      repeat ($urandom_range(0, 2)) chars.insert($urandom_range(0, chars.size()), CHAR_NL);
    if (chars.size() == 0) chars.insert(0, strip_q ? CHAR_NL : rand_alpha());
    foreach (chars[i]) send_char(chars[i], i == chars.size() - 1);
  endtask

  task automatic send_noise_string();
    int n;
    n = $urandom_range(1, 8);
    for (int i = 0; i < n; i++) send_char(8'($urandom_range(0, 255)), i == n - 1);
  endtask

  // Full chunks in both alphabets, '=' padding at position 2, '.' at position 3
  task automatic test_chunks_and_padding();
    write_strip(1'b0);
    tx_mode = 1;
    rx_mode = 1;
    send_text("TWFu", 1'b1);
    send_text("+/-_", 1'b0);
    send_text("QQ=\377", 1'b1);
    send_text("QUI.", 1'b1);
  endtask

  // Padding too early, truncation, bad characters, a zero byte
  task automatic test_errors();
    send_char(CHAR_EQ, 1'b1);
    send_char("Q", 1'b1);
    send_text("Q*QQ", 1'b1);
    send_char(8'h00, 1'b1);
    send_char(CHAR_NL, 1'b1);
  endtask

  // Dropped newlines, including one that closes the string and an empty string
  task automatic test_newline_strip();
    write_strip(1'b1);
    send_text("QQ\n\n", 1'b1);
    send_char(CHAR_NL, 1'b1);
  endtask

  task automatic test_random_phase(input logic strip, input int n_items,
                                   input int txm, input int rxm);
    int start;
    int pick;
    write_strip(strip);
    tx_mode = txm;
    rx_mode = rxm;
    start   = chars_sent;
    while (chars_sent - start < n_items) begin
      pick = $urandom_range(0, 9);
      if (pick < 7)      send_random_string(1'b0);
      else if (pick < 9) send_random_string(1'b1);
      else               send_noise_string();
      // now and then let the output catch up completely
      if ($urandom_range(0, 30) == 0) wait_drained();
    end
  endtask

  initial begin
    rst_n       <= 1'b0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    in_tlast    <= 1'b0;
    out_tready  <= 1'b0;
    strip_q = 1'b0;
    pos_q   = '0;
    prev_q  = '0;
    skip_q  = 1'b0;
    err_q   = 1'b0;
    tx_mode = 0;
    rx_mode = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_chunks_and_padding();
    test_errors();
    test_newline_strip();
    test_random_phase(1'b0, 300, 1, 1);
    test_random_phase(1'b1, 250, 0, 0);
    test_random_phase(1'b0, 250, 1, 2);
    test_random_phase(1'b1, 300, 1, 1);

    wait_drained();
    if (decoded_q.size() != 0) begin
      $error("%0d expected results never arrived", decoded_q.size());
      fail_cnt++;
    end
    $display("Decoded %0d strings from %0d characters in %0d cycles",
             strings_sent, chars_sent, cycle_cnt);
    $display("Checked %0d results: %0d bytes, %0d strings flagged bad",
             results_seen, bytes_seen, bad_strings);
    if (fail_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
